// ===== hw/rtl/quadtree_refine_by_size_field_macros.svh =====
// assertion macros for the quadtree refinement block
// used by the top level only, relies on clk and rst_n in scope
`ifndef QUADTREE_REFINE_BY_SIZE_FIELD_MACROS_SVH
`define QUADTREE_REFINE_BY_SIZE_FIELD_MACROS_SVH

// same-cycle implication
`define QTR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define QTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/qtr_pkg.sv =====
// shared types and constants of the quadtree refinement block
// no dependencies
package qtr_pkg;

  // input modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TOLERANCE = 2'd0;
  localparam logic [1:0] REG_TARGET    = 2'd1;
  localparam logic [1:0] REG_BASE      = 2'd2;
  localparam logic [1:0] REG_RADIUS_SQ = 2'd3;

  // field widths
  localparam int CRD_W  = 24;
  localparam int R2_W   = 50;
  localparam int QUO_W  = 32;
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQR_W  = 25;
  localparam int H_W    = 26;

  // reset values of the registers
  localparam logic [15:0] TOL_RST    = 16'd0;
  localparam logic [23:0] TARGET_RST = 24'd4096;
  localparam logic [23:0] BASE_RST   = 24'd16384;

  // corner pairs compared for the refinement flag
  localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
  localparam logic [2:0] PAIR_LAST  = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_DX, ST_SQX, ST_SQY, ST_D2, ST_DIV, ST_SQ_MUL, ST_SQ_CMP,
    ST_HMUL, ST_HADD, ST_DGX, ST_DGY, ST_DGS, ST_THR, ST_THW, ST_PMUL, ST_PCMP,
    ST_DONE
  } qtr_state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [R2_W-1:0] num;
    logic [R2_W-1:0] den;
  } qtr_div_req_t;

endpackage

// ===== hw/rtl/qtr_if.sv =====
// channel interfaces of the quadtree refinement block
// no dependencies
interface qtr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic signed [23:0] x_low;
  logic signed [23:0] y_low;
  logic signed [23:0] x_high;
  logic signed [23:0] y_high;
  modport source (output valid, mode, x_low, y_low, x_high, y_high, input ready);
  modport sink (input valid, mode, x_low, y_low, x_high, y_high, output ready);
endinterface

interface qtr_out_if;
  logic       valid;
  logic       ready;
  logic       subdivide;
  logic       status;
  logic [8:0] source_count;
  modport source (output valid, subdivide, status, source_count, input ready);
  modport sink (input valid, subdivide, status, source_count, output ready);
endinterface

interface qtr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [49:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== hw/rtl/quadtree_refine_by_size_field.sv =====
// quadtree refinement test over a table of corner sources, top level
// clear, load, spare mode and queries of an empty table give their result in the cycle after the
// input transfer; a query over N sources runs, for each source and centre, a 32-step divider and a
// 17-step square root on one shared 28x28 multiplier, then the diagonal root and the six pairs
// one item in flight at a time; reset empties the table and loads default registers
`include "quadtree_refine_by_size_field_macros.svh"
module quadtree_refine_by_size_field import qtr_pkg::*; #(
  parameter int MAX_SOURCES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  qtr_in_if.sink    in_ch,
  qtr_out_if.source out_ch,
  qtr_cfg_if.sink   cfg_ch
);
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  qtr_state_t state_r, state_nxt;

  // configuration registers
  logic [15:0]     tol_r;
  logic [23:0]     target_r, base_r;
  logic [R2_W-1:0] r2_r;

  logic [CW-1:0]   cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [1:0]      corner_r, corner_nxt;
  logic [2:0]      pair_r, pair_nxt;
  logic signed [26:0] xa_r, xb_r, ya_r, yb_r, xa_nxt, xb_nxt, ya_nxt, yb_nxt;
  logic [24:0]     awx_r, awy_r, awx_nxt, awy_nxt;
  logic [MUL_W-1:0] adx_r, ady_r, adx_nxt, ady_nxt;
  logic [53:0]     acc_r, acc_nxt;
  logic [R2_W-1:0] sqx_r, sqx_nxt;
  logic [SQR_W-1:0] sq_r, sq_nxt;
  logic [4:0]      sqk_r, sqk_nxt;
  logic            diag_r, diag_nxt;
  logic [H_W-1:0]  best_r, best_nxt;
  logic [H_W-1:0]  hc_r [4];
  logic [H_W-1:0]  hc_nxt [4];
  logic [MUL_W-1:0] thr_r, thr_nxt;
  logic [H_W-1:0]  pd_r, pd_nxt;
  logic            mxz_r, mxz_nxt;
  logic            sub_r, sub_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [MUL_W-1:0] mul_a, mul_b;

  logic            out_valid_r, out_valid_nxt, out_sub_r, out_sub_nxt;
  logic            out_stat_r, out_stat_nxt;
  logic [8:0]      out_cnt_r, out_cnt_nxt;

  logic            ram_we;
  logic [47:0]     ram_rd;
  qtr_div_req_t    div_req;
  logic            div_done;
  logic [QUO_W-1:0] div_quo;

  logic            in_fire;
  logic [23:0]     diff;
  logic signed [27:0] cx, cy, dx, dy;
  logic [53:0]     sum_sq;
  logic [R2_W-1:0] d2;
  logic [SQR_W-1:0] trial;
  logic            take_h;
  logic [H_W-1:0]  h_val, h_min, pa, pb, pmx;
  logic signed [24:0] wx, wy;
  logic signed [26:0] xl_e, yl_e, xh_e, yh_e;

  qtr_ram #(.WIDTH(2 * CRD_W), .DEPTH(MAX_SOURCES), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data ({in_ch.x_low, in_ch.y_low}),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd)
  );

  qtr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ch.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign diff         = (base_r > target_r) ? base_r - target_r : '0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RST;
      target_r <= TARGET_RST;
      base_r   <= BASE_RST;
      r2_r     <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_TOLERANCE: tol_r    <= cfg_ch.wdata[15:0];
        REG_TARGET:    target_r <= cfg_ch.wdata[23:0];
        REG_BASE:      base_r   <= cfg_ch.wdata[23:0];
        REG_RADIUS_SQ: r2_r     <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer and datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; idx_nxt = idx_r; corner_nxt = corner_r; pair_nxt = pair_r;
    xa_nxt = xa_r; xb_nxt = xb_r; ya_nxt = ya_r; yb_nxt = yb_r;
    awx_nxt = awx_r; awy_nxt = awy_r; adx_nxt = adx_r; ady_nxt = ady_r;
    acc_nxt = acc_r; sqx_nxt = sqx_r; sq_nxt = sq_r; sqk_nxt = sqk_r;
    diag_nxt = diag_r; best_nxt = best_r; hc_nxt = hc_r; thr_nxt = thr_r;
    pd_nxt = pd_r; mxz_nxt = mxz_r; sub_nxt = sub_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sub_nxt = out_sub_r; out_stat_nxt = out_stat_r; out_cnt_nxt = out_cnt_r;
    mul_a = '0; mul_b = '0;
    ram_we = 1'b0;
    div_req = '{start: 1'b0, num: d2, den: r2_r};
    take_h = 1'b0; h_val = '0;

    xl_e = 27'(in_ch.x_low); yl_e = 27'(in_ch.y_low);
    xh_e = 27'(in_ch.x_high); yh_e = 27'(in_ch.y_high);
    wx = 25'(in_ch.x_high) - 25'(in_ch.x_low);
    wy = 25'(in_ch.y_high) - 25'(in_ch.y_low);
    cx = (corner_r == 2'd1 || corner_r == 2'd2) ? 28'(xb_r) : 28'(xa_r);
    cy = corner_r[1] ? 28'(yb_r) : 28'(ya_r);
    dx = cx - (28'($signed(ram_rd[47:24])) <<< 2);
    dy = cy - (28'($signed(ram_rd[23:0])) <<< 2);
    sum_sq = acc_r + prod_r[53:0];
    d2 = sum_sq[53:4];
    trial = sq_r | (SQR_W'(1) << sqk_r);
    pa = hc_r[PAIR_A[pair_r]];
    pb = hc_r[PAIR_B[pair_r]];
    pmx = (pa > pb) ? pa : pb;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_sub_nxt = 1'b0;
          out_stat_nxt = 1'b0;
          priority if (in_ch.mode == MODE_CLEAR) begin
            cnt_nxt = '0;
            out_valid_nxt = 1'b1;
          end else if (in_ch.mode == MODE_LOAD) begin
            if (cnt_r < CW'(MAX_SOURCES)) begin
              ram_we = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              out_stat_nxt = 1'b1;
            end
            out_valid_nxt = 1'b1;
          end else if (in_ch.mode == MODE_QUERY && cnt_r != '0) begin
            xa_nxt = (xl_e <<< 1) + xl_e + xh_e;
            xb_nxt = (xh_e <<< 1) + xh_e + xl_e;
            ya_nxt = (yl_e <<< 1) + yl_e + yh_e;
            yb_nxt = (yh_e <<< 1) + yh_e + yl_e;
            awx_nxt = wx[24] ? 25'(-wx) : 25'(wx);
            awy_nxt = wy[24] ? 25'(-wy) : 25'(wy);
            idx_nxt = '0; corner_nxt = '0; sub_nxt = 1'b0;
            best_nxt = '1;
            state_nxt = ST_RD;
          end else begin
            out_valid_nxt = 1'b1;
          end
          out_cnt_nxt = 9'(cnt_nxt);
        end
      end
      ST_RD: state_nxt = ST_DX;
      ST_DX: begin
        adx_nxt = dx[27] ? MUL_W'(-dx) : MUL_W'(dx);
        ady_nxt = dy[27] ? MUL_W'(-dy) : MUL_W'(dy);
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        mul_a = adx_r; mul_b = adx_r;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        acc_nxt = prod_r[53:0];
        mul_a = ady_r; mul_b = ady_r;
        state_nxt = ST_D2;
      end
      ST_D2: begin
        sq_nxt = '0; sqk_nxt = 5'd16; diag_nxt = 1'b0;
        priority if (d2 > r2_r) begin
          take_h = 1'b1; h_val = H_W'(base_r);
        end else if (r2_r == '0) begin
          state_nxt = ST_HMUL;
        end else if (d2 == r2_r) begin
          sqx_nxt = R2_W'(64'h1_0000_0000);
          state_nxt = ST_SQ_MUL;
        end else begin
          div_req.start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sqx_nxt = R2_W'(div_quo);
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        mul_a = MUL_W'(trial); mul_b = MUL_W'(trial);
        state_nxt = ST_SQ_CMP;
      end
      ST_SQ_CMP: begin
        if (prod_r <= PROD_W'(sqx_r)) sq_nxt = trial;
        if (sqk_r == '0) begin
          state_nxt = diag_r ? ST_THR : ST_HMUL;
        end else begin
          sqk_nxt = sqk_r - 5'd1;
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_HMUL: begin
        mul_a = MUL_W'(sq_r[16:0]); mul_b = MUL_W'(diff);
        state_nxt = ST_HADD;
      end
      ST_HADD: begin
        take_h = 1'b1;
        h_val = H_W'(target_r) + H_W'(prod_r[40:16]);
      end
      ST_DGX: begin
        mul_a = MUL_W'(awx_r); mul_b = MUL_W'(awx_r);
        state_nxt = ST_DGY;
      end
      ST_DGY: begin
        acc_nxt = prod_r[53:0];
        mul_a = MUL_W'(awy_r); mul_b = MUL_W'(awy_r);
        state_nxt = ST_DGS;
      end
      ST_DGS: begin
        sqx_nxt = sum_sq[R2_W-1:0];
        sq_nxt = '0; sqk_nxt = 5'd24; diag_nxt = 1'b1;
        state_nxt = ST_SQ_MUL;
      end
      ST_THR: begin
        mul_a = MUL_W'(tol_r); mul_b = MUL_W'(sq_r);
        state_nxt = ST_THW;
      end
      ST_THW: begin
        thr_nxt = prod_r[MUL_W-1:0];
        pair_nxt = '0;
        state_nxt = (prod_r[PROD_W-1:MUL_W] != '0) ? ST_DONE : ST_PMUL;
      end
      ST_PMUL: begin
        mul_a = thr_r; mul_b = MUL_W'(pmx);
        pd_nxt = (pa > pb) ? pa - pb : pb - pa;
        mxz_nxt = (pmx == '0);
        state_nxt = ST_PCMP;
      end
      ST_PCMP: begin
        if (!mxz_r && (PROD_W'({pd_r, 28'd0}) > prod_r)) sub_nxt = 1'b1;
        if (pair_r == PAIR_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          pair_nxt = pair_r + 3'd1;
          state_nxt = ST_PMUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_sub_nxt = sub_r;
          out_stat_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // fold one source's size into the running minimum
    h_min = (h_val < best_r) ? h_val : best_r;
    if (take_h) begin
      if (idx_r + 1'b1 == cnt_r) begin
        hc_nxt[corner_r] = h_min;
        best_nxt = '1;
        idx_nxt = '0;
        if (corner_r == 2'd3) begin
          state_nxt = ST_DGX;
        end else begin
          corner_nxt = corner_r + 2'd1;
          state_nxt = ST_RD;
        end
      end else begin
        best_nxt = h_min;
        idx_nxt = idx_r + 1'b1;
        state_nxt = ST_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt; corner_r <= corner_nxt; pair_r <= pair_nxt;
    xa_r <= xa_nxt; xb_r <= xb_nxt; ya_r <= ya_nxt; yb_r <= yb_nxt;
    awx_r <= awx_nxt; awy_r <= awy_nxt; adx_r <= adx_nxt; ady_r <= ady_nxt;
    acc_r <= acc_nxt; sqx_r <= sqx_nxt; sq_r <= sq_nxt; sqk_r <= sqk_nxt;
    diag_r <= diag_nxt; best_r <= best_nxt; hc_r <= hc_nxt; thr_r <= thr_nxt;
    pd_r <= pd_nxt; mxz_r <= mxz_nxt; sub_r <= sub_nxt;
    out_sub_r <= out_sub_nxt; out_stat_r <= out_stat_nxt; out_cnt_r <= out_cnt_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.subdivide    = out_sub_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.source_count = out_cnt_r;

  // table fill never passes its depth
  `QTR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_SOURCES))
  // a query over a nonempty table keeps the input closed next cycle
  `QTR_ASSERT_NEXT(a_query_busy, in_fire && in_ch.mode == MODE_QUERY && cnt_r != '0, !in_ch.ready)
  // a load into a table with room grows it by one
  `QTR_ASSERT_NEXT(a_load_grow, ram_we, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// ===== hw/rtl/qtr_ram.sv =====
// generic single-port-write, registered-read ram
// no dependencies
module qtr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hw/rtl/qtr_div.sv =====
// restoring divider, one quotient bit per cycle, floor(num * 2^32 / den)
// depends on qtr_pkg, expects num < den
module qtr_div import qtr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  qtr_div_req_t       req,
  output logic               done,
  output logic [QUO_W-1:0]   quo
);
  logic              busy_r, busy_nxt;
  logic [5:0]        k_r, k_nxt;
  logic [R2_W-1:0]   rem_r, rem_nxt;
  logic [R2_W-1:0]   den_r, den_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic              done_r, done_nxt;
  logic [R2_W:0]     shifted;

  // one shift-subtract step a cycle
  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, 1'b0};
    if (req.start) begin
      busy_nxt = 1'b1;
      k_nxt    = 6'(QUO_W);
      rem_nxt  = req.num;
      den_nxt  = req.den;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = R2_W'(shifted - {1'b0, den_r});
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = R2_W'(shifted);
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
      k_nxt = k_r - 6'd1;
      if (k_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ===== tb/tb.sv =====
// testbench of the quadtree size-field refinement block: directed and random
// clear/load/query traffic checked against a bit-exact fixed-point predictor
// depends on qtr_pkg, qtr_if and quadtree_refine_by_size_field
`timescale 1ns / 1ps

// expected results of the refinement block, with its own copy of the table
class refine_scoreboard;
  typedef struct {
    bit       subdivide;
    bit       status;
    bit [8:0] source_count;
  } verdict_t;

  localparam int TABLE_DEPTH = 256;

  verdict_t   pending[$];
  longint     src_x[TABLE_DEPTH];
  longint     src_y[TABLE_DEPTH];
  int         held;
  bit [63:0]  tol, tgt, bas, rad_sq;
  int         mismatches;

  function new();
    held = 0;
    tol = 0;
    tgt = 4096;
    bas = 16384;
    rad_sq = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [49:0] val);
    case (idx)
      qtr_pkg::REG_TOLERANCE: tol = val[15:0];
      qtr_pkg::REG_TARGET:    tgt = val[23:0];
      qtr_pkg::REG_BASE:      bas = val[23:0];
      qtr_pkg::REG_RADIUS_SQ: rad_sq = val;
      default: ;
    endcase
  endfunction

  // floor square root, bit by bit
  function bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // truncated d2 / r2 as Q0.32, saturating at one
  function bit [63:0] frac_q32(bit [63:0] d2, bit [63:0] r2);
    bit [63:0] q, rem;
    q = 0;
    rem = d2;
    if (d2 >= r2) return 64'd1 << 32;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= r2) begin
        rem = rem - r2;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // minimum element size at a centre given in quarter coordinate units
  function bit [63:0] size_near(longint cx4, longint cy4);
    bit [63:0] diff, best, d2, h, root;
    longint dx, dy;
    diff = (bas > tgt) ? bas - tgt : 0;
    best = '1;
    for (int i = 0; i < held; i++) begin
      dx = cx4 - src_x[i] * 4;
      dy = cy4 - src_y[i] * 4;
      d2 = (64'(dx * dx) + 64'(dy * dy)) >> 4;
      if (d2 > rad_sq) begin
        h = bas;
      end else begin
        root = floor_root((rad_sq == 0) ? 64'd0 : frac_q32(d2, rad_sq));
        h = tgt + ((root * diff) >> 16);
      end
      if (h < best) best = h;
    end
    return best;
  endfunction

  function bit pair_split(bit [63:0] a, bit [63:0] b, bit [63:0] thr);
    bit [63:0] mx, d;
    mx = (a > b) ? a : b;
    d = (a > b) ? a - b : b - a;
    if (mx == 0) return 0;
    if (thr >= (64'd1 << 28)) return 0;
    return (d << 28) > thr * mx;
  endfunction

  // accepted input transfer: update the table and queue the expected result
  function void note_input(logic [1:0] mode, logic signed [23:0] xl, logic signed [23:0] yl,
                           logic signed [23:0] xh, logic signed [23:0] yh);
    verdict_t v;
    bit [63:0] hs[4];
    longint xa, xb, ya, yb, wx, wy;
    bit [63:0] thr;
    v = '{default: 0};
    if (mode == qtr_pkg::MODE_CLEAR) begin
      held = 0;
    end else if (mode == qtr_pkg::MODE_LOAD) begin
      if (held < TABLE_DEPTH) begin
        src_x[held] = xl;
        src_y[held] = yl;
        held++;
      end else begin
        v.status = 1;
      end
    end else if (mode == qtr_pkg::MODE_QUERY && held > 0) begin
      xa = 3 * longint'(xl) + xh;
      xb = longint'(xl) + 3 * longint'(xh);
      ya = 3 * longint'(yl) + yh;
      yb = longint'(yl) + 3 * longint'(yh);
      hs[0] = size_near(xa, ya);
      hs[1] = size_near(xb, ya);
      hs[2] = size_near(xb, yb);
      hs[3] = size_near(xa, yb);
      wx = longint'(xh) - xl;
      wy = longint'(yh) - yl;
      thr = tol * floor_root(64'(wx * wx) + 64'(wy * wy));
      for (int i = 0; i < 4; i++)
        for (int j = i + 1; j < 4; j++)
          if (pair_split(hs[i], hs[j], thr)) v.subdivide = 1;
    end
    v.source_count = held[8:0];
    pending.insert(pending.size(), v);
  endfunction

  // accepted result transfer against the oldest expectation
  function void check_result(logic sub, logic st, logic [8:0] cnt);
    verdict_t v;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result transfer");
      return;
    end
    v = pending.pop_front();
    if (sub !== v.subdivide || st !== v.status || cnt !== v.source_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result mismatch exp sub=%0d st=%0d cnt=%0d got sub=%0d st=%0d cnt=%0d",
                 v.subdivide, v.status, v.source_count, sub, st, cnt);
    end
  endfunction
endclass

module tb;
  import qtr_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         ITEM_GOAL   = 1100;
  localparam int         PHASE_ITEMS = (ITEM_GOAL - 300) / 6;
  localparam longint     CYCLE_CAP   = 12000000;

  logic clk;
  logic rst_n;
  longint cycles;
  bit steady;
  bit hold_req;
  int hold_left;
  int sent;

  refine_scoreboard sb;

  qtr_in_if  in_ch ();
  qtr_out_if out_ch ();
  qtr_cfg_if cfg_ch ();

  quadtree_refine_by_size_field #(.MAX_SOURCES(256)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls and long hold-offs on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_req <= 1'b0;
      hold_left <= 700;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.subdivide, out_ch.status, out_ch.source_count);
  end

  // one input transfer, with random gaps ahead of it
  task automatic send_item(logic [1:0] mode, logic signed [23:0] xl, logic signed [23:0] yl,
                           logic signed [23:0] xh, logic signed [23:0] yh);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 34) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.x_low = xl;
    in_ch.y_low = yl;
    in_ch.x_high = xh;
    in_ch.y_high = yh;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(mode, xl, yl, xh, yh);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [49:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wdata = val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_all(logic [15:0] tol, logic [23:0] tgt, logic [23:0] bas,
                           logic [49:0] r2);
    wait_drained();
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_BASE, bas);
    write_reg(REG_RADIUS_SQ, r2);
  endtask

  function automatic logic signed [23:0] any_coord();
    return 24'($urandom());
  endfunction

  // coordinate within -32768..+32767 of a cluster center
  function automatic logic signed [23:0] near(int c);
    return 24'(c + $signed($urandom_range(65535)) - 32768);
  endfunction

  initial begin
    int cx, cy, n, a, b;
    logic signed [23:0] p, q;
    sb = new();
    cycles = 0;
    steady = 0;
    hold_req = 0;
    hold_left = 0;
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_CLEAR;
    in_ch.x_low = '0;
    in_ch.y_low = '0;
    in_ch.x_high = '0;
    in_ch.y_high = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_TOLERANCE;
    cfg_ch.wdata = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset registers, empty table, spare mode
    send_item(MODE_QUERY, -24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096);
    send_item(MODE_SPARE, '1, '1, '1, '1);
    send_item(MODE_LOAD, 24'sd0, 24'sd0, '1, '1);
    // zero radius: only a source at distance zero hits target
    send_item(MODE_QUERY, -24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096);
    send_item(MODE_QUERY, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    write_all(16'd1, 24'd4096, 24'd65536, 50'd16 << 24);
    send_item(MODE_LOAD, 24'sd8192, 24'sd0, 24'sd0, 24'sd0);
    send_item(MODE_QUERY, -24'sd8192, -24'sd8192, 24'sd8192, 24'sd8192);
    // inverted box
    send_item(MODE_QUERY, 24'sd8192, 24'sd8192, -24'sd8192, -24'sd8192);
    // coordinate extremes
    send_item(MODE_LOAD, -24'sd8388608, 24'sd8388607, 24'sd0, 24'sd0);
    send_item(MODE_QUERY, -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607);
    send_item(MODE_QUERY, 24'sd8388607, 24'sd8388607, -24'sd8388608, -24'sd8388608);
    // largest tolerance and radius, base below target
    write_all(16'hFFFF, 24'hFFFFFF, 24'd0, '1);
    send_item(MODE_QUERY, -24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096);
    send_item(MODE_CLEAR, '1, '1, '1, '1);
    send_item(MODE_QUERY, -24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096);
    // all-zero sizes make every pair have a zero maximum
    write_all(16'd0, 24'd0, 24'd0, 50'd0);
    send_item(MODE_LOAD, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_item(MODE_QUERY, -24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096);
    write_all(16'hFFFF, 24'hFFFFFF, 24'd1, 50'd1 << 30);
    send_item(MODE_QUERY, -24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096);

    // random phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(16'd2000, 24'd4096, 24'd16384, 50'd64 << 24);
        1: write_all(16'($urandom()), 24'($urandom()), 24'($urandom()),
                     50'({$urandom(), $urandom()}));
        2: write_all(16'd0, 24'd0, 24'hFFFFFF, 50'd4 << 24);
        3: write_all(16'hFFFF, 24'd100, 24'd200000, 50'd400 << 24);
        4: write_all(16'($urandom_range(5000)), 24'($urandom_range(20000)),
                     24'($urandom_range(200000)), 50'($urandom_range(1 << 20)) << 20);
        default: write_all(16'd300, 24'hFFFFFF, 24'd0, '1);
      endcase
      steady = (ph == 2);
      while (sent < 20 + (ph + 1) * PHASE_ITEMS) begin
        if (ph == 3 && sent > 20 + 3 * PHASE_ITEMS + 60 && !hold_req && hold_left == 0
            && cycles > 0 && sb.held < 300) begin
          // receiver backs off once while traffic keeps coming
          if (!steady) hold_req = (sent % 97 == 0);
        end
        a = $urandom_range(99);
        if (a < 5) begin
          send_item(MODE_CLEAR, any_coord(), any_coord(), any_coord(), any_coord());
        end else if (a < 8) begin
          send_item(MODE_SPARE, any_coord(), any_coord(), any_coord(), any_coord());
        end else if (a < 12) begin
          // noise: query with arbitrary corners, small table only
          if (sb.held > 6) send_item(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
          send_item(MODE_QUERY, any_coord(), any_coord(), any_coord(), any_coord());
        end else begin
          // well-formed cluster: clear, a few sources, several nearby boxes
          cx = $signed(any_coord()) / 2;
          cy = $signed(any_coord()) / 2;
          send_item(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++)
            send_item(MODE_LOAD, near(cx), near(cy), any_coord(), any_coord());
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            p = near(cx);
            q = near(cy);
            b = $urandom_range(1, 40000);
            send_item(MODE_QUERY, p, q, 24'(p + b), 24'(q + $urandom_range(1, 40000)));
          end
        end
      end
      if (ph == 3) begin
        // a sure hold-off with the sender still offering
        @(negedge clk);
        in_ch.valid = 1'b0;
        hold_req = 1;
        send_item(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        for (int k = 0; k < 6; k++)
          send_item(MODE_LOAD, any_coord(), any_coord(), any_coord(), any_coord());
      end
    end

    // fill the table, overflow it, query it once in full, then empty it
    steady = 0;
    send_item(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    for (int k = 0; k < 258; k++)
      send_item(MODE_LOAD, near(0), near(0), any_coord(), any_coord());
    send_item(MODE_QUERY, -24'sd20000, -24'sd20000, 24'sd20000, 24'sd20000);
    send_item(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0, 24'sd0);

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/qtr_pkg.sv
hw/rtl/qtr_if.sv
hw/rtl/qtr_ram.sv
hw/rtl/qtr_div.sv
hw/rtl/quadtree_refine_by_size_field.sv
tb/tb.sv
